// ----- rtl/fatent_pkg.sv -----
// ----------------------------------------------------------------------------
// fatent_pkg
// Shared types and constants of the FAT12/FAT16 entry engine.
// ----------------------------------------------------------------------------
package fatent_pkg;

  // default store size in bytes
  localparam int unsigned STORE_BYTES_DEF = 16384;

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SADDR_W   = 14;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CLUS_W    = 16;
  localparam int unsigned ROOT_W    = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 12;
  // byte offset of an entry: up to 2 * 65535 + 1
  localparam int unsigned OFF_W     = CLUS_W + 2;

  // chain marks
  localparam logic [CLUS_W-1:0] MARK_EOC  = 16'hFFFF;
  localparam logic [CLUS_W-1:0] MARK_BAD  = 16'hFFF7;
  localparam logic [11:0]       RES12_LOW = 12'hFF0;
  localparam logic [3:0]        RES16_NIB = 4'hF;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SET    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_SECTORS = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word
    logic execute;  // read data is valid: compute result, write store
  } cmd_t;

endpackage

// ----- rtl/fat12_fat16_entry_engine.sv -----
// ----------------------------------------------------------------------------
// fat12_fat16_entry_engine
// FAT12/FAT16 cluster chain lookup over a byte-loaded FAT store.
// ----------------------------------------------------------------------------
// Each word is taken when start is high and busy is low. Its result is on the
// result ports with done_o high for exactly one cycle, after the read and
// execute states; the receiver cannot hold results off. busy stays high
// from acceptance until the result is registered, so no word is taken
// before the previous one is finished: the read state covers the registered
// read of the even and odd byte banks, the execute state the unpack /
// read-modify-write that follows it; the next word is taken in the idle state.
// Store contents are undefined until loaded. Config writes are not gated by
// the block and must only be made while it is idle with no result pending.
// ----------------------------------------------------------------------------
module fat12_fat16_entry_engine #(
  parameter int unsigned STORE_BYTES = fatent_pkg::STORE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  output logic                               done_o,
  input  logic                               cfg_we_i,
  input  logic [fatent_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fatent_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic [fatent_pkg::OP_W-1:0]        opcode_i,
  input  logic [fatent_pkg::SADDR_W-1:0]     store_address_i,
  input  logic [fatent_pkg::BYTE_W-1:0]      store_byte_i,
  input  logic [fatent_pkg::CLUS_W-1:0]      cluster_i,
  input  logic                               root_chain_i,
  input  logic [fatent_pkg::CLUS_W-1:0]      entry_value_i,
  output logic [fatent_pkg::CLUS_W-1:0]      next_cluster_o,
  output logic                               status_o,
  output logic                               dirty_o
);
  import fatent_pkg::*;

  cmd_t cmd;

  // sequencer
  fatent_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // datapath
  fatent_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .store_address_i (store_address_i),
    .store_byte_i    (store_byte_i),
    .cluster_i       (cluster_i),
    .root_chain_i    (root_chain_i),
    .entry_value_i   (entry_value_i),
    .next_cluster_o  (next_cluster_o),
    .status_o        (status_o),
    .dirty_o         (dirty_o)
  );

endmodule

// ----- rtl/fatent_ram.sv -----
// ----------------------------------------------------------------------------
// fatent_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fatent_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fatent_ctrl.sv -----
// ----------------------------------------------------------------------------
// fatent_ctrl
// Sequencer: accept a word, wait in the read state for the bank read, execute.
// ----------------------------------------------------------------------------
module fatent_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output fatent_pkg::cmd_t    cmd_o
);
  import fatent_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = start && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_EXEC);

endmodule

// ----- rtl/fatent_dp.sv -----
// ----------------------------------------------------------------------------
// fatent_dp
// Datapath: config registers, input word latch, even/odd byte banks,
// entry pack/unpack and result registers.
// ----------------------------------------------------------------------------
module fatent_dp #(
  parameter int unsigned STORE_BYTES = fatent_pkg::STORE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fatent_pkg::cmd_t                   cmd_i,
  input  logic                               cfg_we_i,
  input  logic [fatent_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fatent_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic [fatent_pkg::OP_W-1:0]        opcode_i,
  input  logic [fatent_pkg::SADDR_W-1:0]     store_address_i,
  input  logic [fatent_pkg::BYTE_W-1:0]      store_byte_i,
  input  logic [fatent_pkg::CLUS_W-1:0]      cluster_i,
  input  logic                               root_chain_i,
  input  logic [fatent_pkg::CLUS_W-1:0]      entry_value_i,
  output logic [fatent_pkg::CLUS_W-1:0]      next_cluster_o,
  output logic                               status_o,
  output logic                               dirty_o
);
  import fatent_pkg::*;

  localparam int unsigned EVEN_DEPTH = (STORE_BYTES + 1) / 2;
  localparam int unsigned ODD_DEPTH  = STORE_BYTES / 2;
  localparam int unsigned EAW = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
  localparam int unsigned OAW = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
  localparam logic [OFF_W-1:0] STORE_LIM = OFF_W'(STORE_BYTES);

  // configuration
  logic              wide_q;
  logic [ROOT_W-1:0] root_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q     <= 1'b0;
      root_sec_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDE_ENTRIES: wide_q     <= cfg_data_i[0];
        REG_ROOT_SECTORS: root_sec_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // input word latch
  opcode_e            op_q;
  logic [SADDR_W-1:0] saddr_q;
  logic [BYTE_W-1:0]  sbyte_q;
  logic [CLUS_W-1:0]  clus_q;
  logic               rootc_q;
  logic [CLUS_W-1:0]  val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_e'(opcode_i);
      saddr_q <= store_address_i;
      sbyte_q <= store_byte_i;
      clus_q  <= cluster_i;
      rootc_q <= root_chain_i;
      val_q   <= entry_value_i;
    end
  end

  // entry offset and bank addresses
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  off_half;
  logic [OFF_W-1:0]  ev_full;
  logic [OFF_W-1:0]  ld_ext;
  logic [OFF_W-1:0]  ld_half;
  logic              entry_fits;
  logic              load_fits;
  logic [EAW-1:0]    ev_raddr;
  logic [OAW-1:0]    od_raddr;

  always_comb begin
    if (wide_q) off = {1'b0, clus_q, 1'b0};
    else        off = OFF_W'(clus_q) + OFF_W'(clus_q[CLUS_W-1:1]);
    off_half   = off >> 1;
    ev_full    = off_half + OFF_W'(off[0]);
    ld_ext     = OFF_W'(saddr_q);
    ld_half    = ld_ext >> 1;
    entry_fits = (off + OFF_W'(1)) < STORE_LIM;
    load_fits  = ld_ext < STORE_LIM;
    ev_raddr   = ev_full[EAW-1:0];
    od_raddr   = off_half[OAW-1:0];
  end

  // byte banks
  logic              ev_we, od_we;
  logic [EAW-1:0]    ev_waddr;
  logic [OAW-1:0]    od_waddr;
  logic [BYTE_W-1:0] ev_wdata, od_wdata;
  logic [BYTE_W-1:0] ev_rdata, od_rdata;

  fatent_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (EVEN_DEPTH),
    .AW    (EAW)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  fatent_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ODD_DEPTH),
    .AW    (OAW)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  // entry unpack and repack
  logic [BYTE_W-1:0] b0, b1, nb0, nb1;
  logic [11:0]       v12;
  logic [CLUS_W-1:0] rd_entry;
  logic [CLUS_W:0]   root_next;

  always_comb begin
    b0 = off[0] ? od_rdata : ev_rdata;
    b1 = off[0] ? ev_rdata : od_rdata;

    // read side
    if (clus_q[0]) v12 = {b1, b0[7:4]};
    else           v12 = {b1[3:0], b0};
    if (wide_q)                 rd_entry = {b1, b0};
    else if (v12 >= RES12_LOW)  rd_entry = {RES16_NIB, v12};
    else                        rd_entry = CLUS_W'(v12);

    // write side, nibble merge for packed entries
    if (wide_q) begin
      nb0 = val_q[7:0];
      nb1 = val_q[15:8];
    end else if (clus_q[0]) begin
      nb0 = {val_q[3:0], b0[3:0]};
      nb1 = val_q[11:4];
    end else begin
      nb0 = val_q[7:0];
      nb1 = {b1[7:4], val_q[11:8]};
    end

    root_next = {1'b0, clus_q} + (CLUS_W+1)'(1);
  end

  // bank write control
  always_comb begin
    ev_we    = 1'b0;
    od_we    = 1'b0;
    ev_waddr = ev_raddr;
    od_waddr = od_raddr;
    ev_wdata = off[0] ? nb1 : nb0;
    od_wdata = off[0] ? nb0 : nb1;
    if (cmd_i.execute) begin
      case (op_q)
        OP_LOAD: begin
          ev_waddr = ld_half[EAW-1:0];
          od_waddr = ld_half[OAW-1:0];
          ev_wdata = sbyte_q;
          od_wdata = sbyte_q;
          ev_we    = load_fits && !saddr_q[0];
          od_we    = load_fits && saddr_q[0];
        end
        OP_SET: begin
          ev_we = entry_fits;
          od_we = entry_fits;
        end
        default: ;
      endcase
    end
  end

  // result registers
  logic [CLUS_W-1:0] next_q;
  logic              status_q;
  logic              dirty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      next_q   <= '0;
      status_q <= 1'b0;
      case (op_q)
        OP_LOAD: status_q <= !load_fits;
        OP_LOOKUP: begin
          if (rootc_q) begin
            if (root_next >= (CLUS_W+1)'(root_sec_q)) next_q <= MARK_EOC;
            else next_q <= root_next[CLUS_W-1:0];
          end else if (entry_fits) begin
            next_q <= rd_entry;
          end else begin
            next_q   <= MARK_BAD;
            status_q <= 1'b1;
          end
        end
        OP_SET:  status_q <= !entry_fits;
        default: ;
      endcase
    end
  end

  // dirty flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else if (cmd_i.execute && (op_q == OP_SET) && entry_fits) begin
      dirty_q <= 1'b1;
    end
  end

  assign next_cluster_o = next_q;
  assign status_o       = status_q;
  assign dirty_o        = dirty_q;

endmodule
